### sv/v2dc_pkg.sv
// Package for the streaming valid-region 2D correlator.
// Holds the image and window sizes, the request and result structs and the line types.
// It has no dependencies.
`default_nettype none

package v2dc_pkg;

  localparam int ImageWidth = 32;
  localparam int WindowSize = 3;
  localparam int DataW      = 16;
  localparam int CoefIdxW   = 4;
  localparam int OutPosW    = 5;

  localparam int TapCount = WindowSize * WindowSize;
  localparam int TapW     = (TapCount > 1) ? $clog2(TapCount) : 1;
  localparam int PosW     = $clog2(ImageWidth);
  localparam int SlotW    = (WindowSize > 1) ? $clog2(WindowSize) : 1;

  // Values of the mode field.
  localparam logic ModeCoef  = 1'b0;
  localparam logic ModePixel = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic [CoefIdxW-1:0]        coef_index;
    logic signed [DataW-1:0]    sample_value;
  } in_req_t;

  typedef struct packed {
    logic signed [DataW-1:0]    filtered_value;
    logic [OutPosW-1:0]         out_row;
    logic [OutPosW-1:0]         out_col;
    logic                       frame_last;
  } out_rsp_t;

  // Position fields that ride along with a result through the arithmetic stages.
  typedef struct packed {
    logic [OutPosW-1:0]         out_row;
    logic [OutPosW-1:0]         out_col;
    logic                       frame_last;
  } pos_meta_t;

  // One line buffer entry: the pixel of one column in every row slot.
  typedef logic [WindowSize-1:0][DataW-1:0] line_entry_t;

endpackage

`default_nettype wire

### sv/v2dc_line_buf.sv
// Line buffer memory of the correlator: one entry per image column, one slot per kept row.
// Synchronous read from a registered output and one write port; depends on v2dc_pkg.
`default_nettype none

module v2dc_line_buf (
  input  wire                       clk_i,
  input  wire                       rd_en_i,
  input  wire [v2dc_pkg::PosW-1:0]  rd_addr_i,
  output v2dc_pkg::line_entry_t     rd_data_o,
  input  wire                       wr_en_i,
  input  wire [v2dc_pkg::PosW-1:0]  wr_addr_i,
  input  v2dc_pkg::line_entry_t     wr_data_i
);
  import v2dc_pkg::*;

  line_entry_t mem_q [ImageWidth];
  line_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### sv/valid_2d_convolution.sv
// Streaming valid-region 2D correlator (square kernel, not flipped), top level.
// A pixel's result passes the window, product and row-sum registers and the output register to valid_o.
// Throughput: one request per cycle, pixel or coefficient, as long as results are taken.
// The line buffer is read at acceptance and written back when the pixel leaves stage 1, at another column.
// Reset clears the pipeline valids, the pixel position and the output valid; the line
// buffer, window and coefficients are not cleared, since no valid window reads stale data.
`default_nettype none

module valid_2d_convolution (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                stall_o,
  input  v2dc_pkg::in_req_t   in_req_i,
  output logic                valid_o,
  input  wire                 stall_i,
  output v2dc_pkg::out_rsp_t  out_rsp_o
);
  import v2dc_pkg::*;

  // The pipeline moves as one. It only holds when the output register carries a result
  // that is not taken and the last arithmetic stage has another result ready for it.
  logic adv;
  logic accept;
  logic acc_pix;

  // Position of the next pixel; slot_q is the row number modulo the window size, which
  // selects the line buffer slot that the current row overwrites.
  logic [PosW-1:0]  pixel_row_q, pixel_col_q;
  logic [SlotW-1:0] slot_q;

  // Stage 1: the request with its position, while the line buffer read completes.
  logic                s1_valid_q;
  logic                s1_pix_q;
  logic [CoefIdxW-1:0] s1_idx_q;
  logic [DataW-1:0]    s1_val_q;
  logic [PosW-1:0]     s1_row_q, s1_col_q;
  logic [SlotW-1:0]    s1_slot_q;

  // Stage 2: window registers hold the pixel's neighborhood; coefficient loads land here.
  logic                s2_valid_q;
  logic                s2_pix_q;
  logic                s2_res_q;
  logic [CoefIdxW-1:0] s2_idx_q;
  logic [DataW-1:0]    s2_val_q;
  pos_meta_t           s2_meta_q;

  // Stage 3 holds the products, stage 4 the per-row sums.
  logic                s3_res_q;
  pos_meta_t           s3_meta_q;
  logic                s4_res_q;
  pos_meta_t           s4_meta_q;

  logic                out_valid_q;
  out_rsp_t            out_q;

  logic [DataW-1:0] window_q [WindowSize][WindowSize];
  logic [DataW-1:0] coef_q   [TapCount];
  logic [DataW-1:0] prod_q   [WindowSize][WindowSize];
  logic [DataW-1:0] prod_d   [WindowSize][WindowSize];
  logic [DataW-1:0] rowsum_q [WindowSize];
  logic [DataW-1:0] rowsum_d [WindowSize];
  logic [DataW-1:0] total_d;

  line_entry_t      rd_data;
  line_entry_t      wr_data;
  logic [DataW-1:0] new_col [WindowSize];
  logic             wr_en;
  logic             s1_res;
  pos_meta_t        s1_meta;
  logic             s2_load_hit;

  assign adv     = !(out_valid_q && stall_i && s4_res_q);
  assign stall_o = !adv;
  assign accept  = valid_i && adv;
  assign acc_pix = accept && (in_req_i.mode == ModePixel);

  // ------------------------------------------------------------------
  // Pixel position, advanced for every accepted pixel.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_row_q <= '0;
      pixel_col_q <= '0;
      slot_q      <= '0;
    end else if (acc_pix) begin
      if (pixel_col_q == PosW'(ImageWidth - 1)) begin
        pixel_col_q <= '0;
        if (pixel_row_q == PosW'(ImageWidth - 1)) begin
          pixel_row_q <= '0;
          slot_q      <= '0;
        end else begin
          pixel_row_q <= pixel_row_q + PosW'(1);
          if (slot_q == SlotW'(WindowSize - 1)) begin
            slot_q <= '0;
          end else begin
            slot_q <= slot_q + SlotW'(1);
          end
        end
      end else begin
        pixel_col_q <= pixel_col_q + PosW'(1);
      end
    end
  end

  // ------------------------------------------------------------------
  // Line buffer. A pixel reads its column when it is accepted and writes the merged
  // entry back when it leaves stage 1. Two pixels in a row never share a column, so the
  // read and the pending write always address different entries.
  // ------------------------------------------------------------------
  assign wr_en = adv && s1_valid_q && s1_pix_q;

  v2dc_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (acc_pix),
    .rd_addr_i (pixel_col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_data)
  );

  // Stage 1 combinational work: pick the older rows out of the line buffer entry in
  // age order, put the new pixel at the bottom, and form the write-back entry.
  always_comb begin
    logic [SlotW:0] src;
    src = '0;
    for (int ki = 0; ki < WindowSize - 1; ki++) begin
      src = (SlotW + 1)'(s1_slot_q) + (SlotW + 1)'(ki + 1);
      if (src >= (SlotW + 1)'(WindowSize)) begin
        src = src - (SlotW + 1)'(WindowSize);
      end
      new_col[ki] = rd_data[src[SlotW-1:0]];
    end
    new_col[WindowSize-1] = s1_val_q;
    wr_data            = rd_data;
    wr_data[s1_slot_q] = s1_val_q;
  end

  assign s1_res = (s1_row_q >= PosW'(WindowSize - 1)) && (s1_col_q >= PosW'(WindowSize - 1));
  assign s1_meta.out_row    = OutPosW'(s1_row_q - PosW'(WindowSize - 1));
  assign s1_meta.out_col    = OutPosW'(s1_col_q - PosW'(WindowSize - 1));
  assign s1_meta.frame_last = (s1_row_q == PosW'(ImageWidth - 1)) &&
                              (s1_col_q == PosW'(ImageWidth - 1));

  // ------------------------------------------------------------------
  // Stage valids.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_res_q   <= 1'b0;
      s4_res_q   <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_res_q   <= s2_valid_q && s2_pix_q && s2_res_q;
      s4_res_q   <= s3_res_q;
    end
  end

  // Stage payloads, all moved together with the valids.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pix_q  <= (in_req_i.mode == ModePixel);
      s1_idx_q  <= in_req_i.coef_index;
      s1_val_q  <= in_req_i.sample_value;
      s1_row_q  <= pixel_row_q;
      s1_col_q  <= pixel_col_q;
      s1_slot_q <= slot_q;

      s2_pix_q  <= s1_pix_q;
      s2_res_q  <= s1_res;
      s2_idx_q  <= s1_idx_q;
      s2_val_q  <= s1_val_q;
      s2_meta_q <= s1_meta;

      s3_meta_q <= s2_meta_q;
      s4_meta_q <= s3_meta_q;
    end
  end

  // Window: shift one column left and take the new column when a pixel leaves stage 1.
  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q && s1_pix_q) begin
      for (int ki = 0; ki < WindowSize; ki++) begin
        for (int kj = 0; kj < WindowSize - 1; kj++) begin
          window_q[ki][kj] <= window_q[ki][kj+1];
        end
        window_q[ki][WindowSize-1] <= new_col[ki];
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: coefficient loads and products. A load is written in program order with
  // the pixels around it, since both pass this stage one at a time.
  // ------------------------------------------------------------------
  assign s2_load_hit = s2_valid_q && !s2_pix_q && (32'(s2_idx_q) < 32'(TapCount));

  always_ff @(posedge clk_i) begin
    if (adv && s2_load_hit) begin
      coef_q[TapW'(s2_idx_q)] <= s2_val_q;
    end
  end

  always_comb begin
    logic [2*DataW-1:0] full;
    full = '0;
    for (int ki = 0; ki < WindowSize; ki++) begin
      for (int kj = 0; kj < WindowSize; kj++) begin
        full = window_q[ki][kj] * coef_q[ki * WindowSize + kj];
        prod_d[ki][kj] = full[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod_d;
    end
  end

  // Stage 3: one sum per kernel row, wrapped to the data width.
  always_comb begin
    for (int ki = 0; ki < WindowSize; ki++) begin
      rowsum_d[ki] = '0;
      for (int kj = 0; kj < WindowSize; kj++) begin
        rowsum_d[ki] = rowsum_d[ki] + prod_q[ki][kj];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rowsum_q <= rowsum_d;
    end
  end

  // Stage 4: the row sums are added into the output register.
  always_comb begin
    total_d = '0;
    for (int ki = 0; ki < WindowSize; ki++) begin
      total_d = total_d + rowsum_q[ki];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s4_res_q) begin
      out_valid_q <= 1'b1;
    end else if (!stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s4_res_q) begin
      out_q.filtered_value <= total_d;
      out_q.out_row        <= s4_meta_q.out_row;
      out_q.out_col        <= s4_meta_q.out_col;
      out_q.frame_last     <= s4_meta_q.frame_last;
    end
  end

  assign valid_o   = out_valid_q;
  assign out_rsp_o = out_q;

`ifndef SYNTHESIS
  // The line buffer read and the write-back never hit the same column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_pix && wr_en) |-> (pixel_col_q != s1_col_q))
    else $error("line buffer read and write collide on one column");

  // A new result appears only after one left the last arithmetic stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s4_res_q))
    else $error("output valid rose without a result from the pipeline");

  // The pipeline holds only while the output register keeps an untaken result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (out_valid_q && s4_res_q))
    else $error("input stalled without a blocked result");

  // The pixel position and its row slot stay inside the image and the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(pixel_col_q) < ImageWidth) && (32'(pixel_row_q) < ImageWidth) &&
    (32'(slot_q) < WindowSize))
    else $error("pixel position out of range");
`endif

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the streaming 3x3 valid-region correlator.
// Depends on v2dc_pkg and valid_2d_convolution; it predicts every output
// pixel from the accepted requests and compares the results field by field.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import v2dc_pkg::*;

  // Generous bound on the whole run, in clock cycles.
  localparam int CycleLimit = 400000;
  // Cycles allowed after the last expected output for stray results to show up.
  localparam int SettleCycles = 8;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     valid_i = 1'b0;
  logic     stall_i = 1'b0;
  in_req_t  in_req  = '0;
  logic     stall_o;
  logic     valid_o;
  out_rsp_t out_rsp;

  valid_2d_convolution DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_i),
    .stall_o  (stall_o),
    .in_req_i (in_req),
    .valid_o  (valid_o),
    .stall_i  (stall_i),
    .out_rsp_o(out_rsp)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the block: kernel taps, line rows, window and the raster
  // position of the next pixel.
  logic [DataW-1:0] coef_taps [TapCount];
  logic [DataW-1:0] line_rows [WindowSize][ImageWidth];
  logic [DataW-1:0] window_px [WindowSize][WindowSize];
  int               next_row = 0;
  int               next_col = 0;

  out_rsp_t pending_outputs[$];
  int       fail_count   = 0;
  int       result_count = 0;
  int       cycle_count  = 0;

  // Random idling on both sides is enabled per phase; hold_len asks the
  // receiver for one long hold-off.
  bit idle_en    = 1'b0;
  int hold_len   = 0;
  int stall_left = 0;

  initial begin
    foreach (coef_taps[i]) coef_taps[i] = '0;
    foreach (line_rows[i, j]) line_rows[i][j] = '0;
    foreach (window_px[i, j]) window_px[i][j] = '0;
  end

  // Applies one request to the shadow state. Returns 1 when a pixel completes
  // a window that lies fully inside the frame, with the expected output.
  function automatic bit convolve_request(input in_req_t req, output out_rsp_t rsp);
    logic [31:0] acc;
    int          r;
    int          c;
    r   = next_row;
    c   = next_col;
    rsp = '0;
    if (req.mode == ModeCoef) begin
      // Indexes beyond the kernel are dropped without any effect.
      if (req.coef_index < TapCount) coef_taps[req.coef_index] = req.sample_value;
      return 1'b0;
    end
    // Slide the window left and pull in the new column from the line rows.
    for (int ki = 0; ki < WindowSize; ki++)
      for (int kj = 0; kj + 1 < WindowSize; kj++)
        window_px[ki][kj] = window_px[ki][kj+1];
    for (int ki = 0; ki + 1 < WindowSize; ki++)
      window_px[ki][WindowSize-1] = line_rows[(r + ki + 1) % WindowSize][c];
    window_px[WindowSize-1][WindowSize-1] = req.sample_value;
    line_rows[r % WindowSize][c] = req.sample_value;
    convolve_request = 1'b0;
    if (r >= WindowSize - 1 && c >= WindowSize - 1) begin
      acc = '0;
      for (int ki = 0; ki < WindowSize; ki++)
        for (int kj = 0; kj < WindowSize; kj++)
          acc += 32'(window_px[ki][kj]) * 32'(coef_taps[ki * WindowSize + kj]);
      rsp.filtered_value = acc[DataW-1:0];
      rsp.out_row        = OutPosW'(r - (WindowSize - 1));
      rsp.out_col        = OutPosW'(c - (WindowSize - 1));
      rsp.frame_last     = (r == ImageWidth - 1) && (c == ImageWidth - 1);
      convolve_request   = 1'b1;
    end
    if (c + 1 >= ImageWidth) begin
      next_col = 0;
      next_row = (r + 1 >= ImageWidth) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
  endfunction

  function automatic in_req_t make_req(input logic mode, input logic [CoefIdxW-1:0] idx,
                                       input logic [DataW-1:0] val);
    in_req_t req;
    req.mode         = mode;
    req.coef_index   = idx;
    req.sample_value = val;
    return req;
  endfunction

  // Sample values lean on the extremes now and then.
  function automatic logic [DataW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return DataW'($urandom);
    endcase
  endfunction

  function automatic in_req_t random_pixel();
    return make_req(ModePixel, CoefIdxW'($urandom), pick_sample());
  endfunction

  // Offers one request and returns right after the edge that accepts it.
  // Valid stays high so that a following request goes out back to back.
  task automatic send_request(input in_req_t req);
    out_rsp_t rsp;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_req  <= req;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (stall_o);
    if (convolve_request(req, rsp)) pending_outputs.push_back(rsp);
  endtask

  // Pauses the sender until every expected output has been taken.
  task automatic drain_outputs();
    valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_outputs.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("mismatch in %s at result %0d: got 0x%h, expected 0x%h",
             what, result_count, got, want);
    fail_count++;
  endtask

  // Every tap is written before any pixel can complete a window, so no
  // output ever reads an unwritten coefficient. Out-of-range indexes must
  // leave the kernel alone.
  task automatic test_kernel_load();
    logic [DataW-1:0] vals [TapCount] = '{16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'h0000,
                                          16'h5a5a, 16'ha5a5, 16'h0003, 16'hfffd};
    for (int i = 0; i < TapCount; i++) send_request(make_req(ModeCoef, CoefIdxW'(i), vals[i]));
    send_request(make_req(ModeCoef, CoefIdxW'(TapCount), 16'h1234));
    send_request(make_req(ModeCoef, 4'hf, 16'hffff));
  endtask

  // A few warm-up pixels at the value extremes; they produce no output yet.
  task automatic test_pixel_extremes();
    logic [DataW-1:0] vals [8] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff,
                                   16'h0001, 16'haaaa, 16'h5555, 16'h8001};
    foreach (vals[i]) send_request(make_req(ModePixel, 4'hf, vals[i]));
  endtask

  // Mostly pixels with random content, with coefficient reloads mid-frame
  // and some loads at indexes the block ignores. Idling is toggled per
  // segment so that quiet stretches appear as well.
  task automatic test_random_stream();
    logic [CoefIdxW-1:0] idx;
    for (int seg = 0; seg < 11; seg++) begin
      idle_en = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 19) == 0) begin
          idx = ($urandom_range(0, 4) == 0) ? CoefIdxW'($urandom_range(TapCount, 15))
                                            : CoefIdxW'($urandom_range(0, TapCount - 1));
          send_request(make_req(ModeCoef, idx, pick_sample()));
        end else begin
          send_request(random_pixel());
        end
      end
    end
  endtask

  // The receiver holds off for a long stretch while pixels keep coming, so
  // the pipeline fills and the block must stall its input.
  task automatic test_backpressure();
    idle_en  = 1'b0;
    hold_len = 120;
    for (int n = 0; n < 60; n++) send_request(random_pixel());
    drain_outputs();
  endtask

  // Finish the current frame to see the last-pixel flag, then run into the
  // next frame where stale line data must never reach a valid window.
  // The tail runs without any idling.
  task automatic test_frame_wrap();
    idle_en = 1'b1;
    while (!(next_row == 0 && next_col == 0)) send_request(random_pixel());
    idle_en = 1'b0;
    send_request(make_req(ModeCoef, CoefIdxW'(TapCount / 2), pick_sample()));
    for (int n = 0; n < WindowSize * ImageWidth + 8; n++) send_request(random_pixel());
  endtask

  // Receiver side: random stall bursts, and the long hold-off on request.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_i <= 1'b1;
      stall_left--;
    end else if (hold_len > 0) begin
      stall_i    <= 1'b1;
      stall_left = hold_len - 1;
      hold_len   = 0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_i    <= 1'b1;
      stall_left = $urandom_range(0, 12);
    end else begin
      stall_i <= 1'b0;
    end
  end

  // Output checker: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    out_rsp_t want;
    if (rst_ni && valid_o && !stall_i) begin
      result_count++;
      if (pending_outputs.size() == 0) begin
        report_mismatch("unexpected result", out_rsp.filtered_value, '0);
      end else begin
        want = pending_outputs.pop_front();
        if (out_rsp.filtered_value !== want.filtered_value)
          report_mismatch("filtered_value", out_rsp.filtered_value, want.filtered_value);
        if (out_rsp.out_row !== want.out_row)
          report_mismatch("out_row", DataW'(out_rsp.out_row), DataW'(want.out_row));
        if (out_rsp.out_col !== want.out_col)
          report_mismatch("out_col", DataW'(out_rsp.out_col), DataW'(want.out_col));
        if (out_rsp.frame_last !== want.frame_last)
          report_mismatch("frame_last", DataW'(out_rsp.frame_last), DataW'(want.frame_last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_kernel_load();
    test_pixel_extremes();
    test_random_stream();
    test_backpressure();
    test_frame_wrap();
    drain_outputs();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
